/* rtl/bdpa_pkg.sv */
`default_nettype none
package bdpa_pkg;

  // Command codes carried in in_tuser.
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_PATCH = 2'd1,
    CMD_START = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Result kinds carried in out_tuser.
  typedef enum logic [1:0] {
    ST_DATA  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  // Configuration register indexes.
  localparam logic CFG_OLD_LENGTH = 1'b0;
  localparam logic CFG_NEW_LENGTH = 1'b1;

  localparam int CTRL_BYTES = 24;

endpackage
`default_nettype wire

/* rtl/bdpa_ram.sv */
`default_nettype none
module bdpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data is registered and holds while no read is issued.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/binary_delta_patch_apply.sv */
`default_nettype none
// Channel  Direction  Handshake             Payload
// in_      slave      in_tvalid/in_tready   tuser command, tdata data_byte, old_address
// out_     master     out_tvalid/out_tready tuser status, tlast last, tdata new_byte, position
// cfg_     write      cfg_we                cfg_index, cfg_wdata
//
// One item can be accepted per cycle while in_tready is high.
// A data result is held in the read stage alongside the registered read of the old
// image store, then moves to the output register.
// Reset (rst_n low at a clock edge) clears the phase and all counters; the old
// image store is not cleared and must be loaded before it is read.
// When the output stalls, one further result item is held in the read stage,
// after which in_tready drops until the output drains.
module binary_delta_patch_apply #(
  parameter int OLD_DEPTH = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [7:0] data_byte, [19:8] old_address, rest zero
  input  wire logic [1:0]  in_tuser,   // [1:0] command
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // [7:0] new_byte, [38:8] new_position, rest zero
  output logic      [1:0]  out_tuser,  // [1:0] status
  output logic             out_tlast,
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [30:0] cfg_wdata
);

  import bdpa_pkg::*;

  localparam int AW = $clog2(OLD_DEPTH);
  // Width wide enough for both the old length register and the store depth.
  localparam int LW = (AW + 1 > 13) ? AW + 1 : 13;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CONTROL,
    PH_DIFF,
    PH_EXTRA,
    PH_DONE,
    PH_ERROR
  } phase_t;

  // One result item on its way to the output.
  typedef struct packed {
    logic [7:0]  data;
    logic        add;     // add the store byte read for this item
    logic [30:0] pos;
    status_t     status;
    logic        last;
  } res_t;

  // Configuration.
  logic [12:0] old_length_r;
  logic [30:0] new_length_r;

  // Patching state.
  phase_t      phase_r,      phase_nxt;
  logic [4:0]  ctrl_cnt_r,   ctrl_cnt_nxt;
  logic [55:0] shift_r,      shift_nxt;
  logic [30:0] diff_len_r,   diff_len_nxt;
  logic [30:0] extra_len_r,  extra_len_nxt;
  logic [31:0] sum_r,        sum_nxt;
  logic [63:0] seek_r,       seek_nxt;
  logic [63:0] old_pos_r,    old_pos_nxt;
  logic [30:0] new_count_r,  new_count_nxt;
  logic [30:0] remaining_r,  remaining_nxt;

  // Read stage and output register.
  logic        s1_valid_r,   s1_valid_nxt;
  res_t        s1_r,         s1_nxt;
  logic        out_valid_r;
  res_t        out_r;
  logic [7:0]  out_byte_r;

  logic        in_fire;
  logic        s1_go;
  logic        res_load;
  cmd_t        cmd;
  logic [7:0]  in_byte;
  logic [31:0] waddr_ext;
  logic        wr_en;
  logic        rd_en;
  logic [7:0]  rd_data;

  logic [63:0] raw;
  logic [62:0] mag;
  logic        len_ok;
  logic [30:0] len;
  logic [31:0] sum_d;
  logic [32:0] sum_e;
  logic [63:0] seek_new;
  logic [LW-1:0] old_len_ext;
  logic [LW-1:0] depth_c;
  logic [LW-1:0] limit;
  logic        in_range;
  logic [30:0] count_inc;
  logic        finish;
  logic [63:0] seek_term;

  assign cmd       = cmd_t'(in_tuser);
  assign in_byte   = in_tdata[7:0];
  assign waddr_ext = {20'd0, in_tdata[19:8]};

  // The read stage moves on when the output register is free or being emptied.
  assign s1_go     = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_go;
  assign in_fire   = in_tvalid && in_tready;

  // Decoding of the eight-byte control value completed by this byte.
  assign raw      = {in_byte, shift_r};
  assign mag      = raw[62:0];
  assign len_ok   = (mag == 63'd0) || (!raw[63] && (mag[62:31] == 32'd0));
  assign len      = mag[30:0];
  assign sum_d    = {1'b0, new_count_r} + {1'b0, len};
  assign sum_e    = {1'b0, sum_r} + {2'b0, len};
  assign seek_new = raw[63] ? (64'd0 - {1'b0, mag}) : {1'b0, mag};

  // The old image is the smaller of the programmed length and the store depth.
  assign old_len_ext = LW'(old_length_r);
  assign depth_c     = LW'(OLD_DEPTH);
  assign limit       = (old_len_ext > depth_c) ? depth_c : old_len_ext;
  assign in_range    = (old_pos_r[63:LW] == '0) && (old_pos_r[LW-1:0] < limit);

  assign count_inc = new_count_r + 31'd1;
  assign finish    = (remaining_r == 31'd1) && !((phase_r == PH_DIFF) && (extra_len_r != '0));
  assign seek_term = finish ? seek_r : 64'd0;

  always_comb begin
    phase_nxt     = phase_r;
    ctrl_cnt_nxt  = ctrl_cnt_r;
    shift_nxt     = shift_r;
    diff_len_nxt  = diff_len_r;
    extra_len_nxt = extra_len_r;
    sum_nxt       = sum_r;
    seek_nxt      = seek_r;
    old_pos_nxt   = old_pos_r;
    new_count_nxt = new_count_r;
    remaining_nxt = remaining_r;
    res_load      = 1'b0;
    s1_nxt        = s1_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;

    if (in_fire) begin
      unique case (cmd)
        CMD_LOAD: begin
          wr_en = (waddr_ext < 32'(OLD_DEPTH));
        end
        CMD_START: begin
          old_pos_nxt   = '0;
          new_count_nxt = '0;
          ctrl_cnt_nxt  = '0;
          diff_len_nxt  = '0;
          extra_len_nxt = '0;
          seek_nxt      = '0;
          remaining_nxt = '0;
          if (new_length_r == '0) begin
            // An empty image is finished at once.
            phase_nxt = PH_DONE;
            res_load  = 1'b1;
            s1_nxt    = '{data: 8'd0, add: 1'b0, pos: 31'd0, status: ST_DONE, last: 1'b1};
          end else begin
            phase_nxt = PH_CONTROL;
          end
        end
        CMD_PATCH: begin
          unique case (phase_r)
            PH_CONTROL: begin
              ctrl_cnt_nxt = ctrl_cnt_r + 5'd1;
              // Bytes arrive least significant first and enter at the top, so after
              // seven of them the low seven bytes of the value sit in order.
              shift_nxt    = {in_byte, shift_r[55:8]};
              if (ctrl_cnt_r[2:0] == 3'd7) begin
                unique case (ctrl_cnt_r[4:3])
                  2'd0: begin
                    if (!len_ok || (sum_d > {1'b0, new_length_r})) begin
                      phase_nxt = PH_ERROR;
                      res_load  = 1'b1;
                      s1_nxt    = '{data: 8'd0, add: 1'b0, pos: new_count_r,
                                    status: ST_ERROR, last: 1'b1};
                    end else begin
                      diff_len_nxt = len;
                      sum_nxt      = sum_d;
                    end
                  end
                  2'd1: begin
                    if (!len_ok || (sum_e > {2'b0, new_length_r})) begin
                      phase_nxt = PH_ERROR;
                      res_load  = 1'b1;
                      s1_nxt    = '{data: 8'd0, add: 1'b0, pos: new_count_r,
                                    status: ST_ERROR, last: 1'b1};
                    end else begin
                      extra_len_nxt = len;
                    end
                  end
                  default: begin
                    seek_nxt = seek_new;
                    if (diff_len_r != '0) begin
                      phase_nxt     = PH_DIFF;
                      remaining_nxt = diff_len_r;
                    end else if (extra_len_r != '0) begin
                      phase_nxt     = PH_EXTRA;
                      remaining_nxt = extra_len_r;
                    end else begin
                      // Both lengths zero: the triple ends here.
                      old_pos_nxt  = old_pos_r + seek_new;
                      ctrl_cnt_nxt = '0;
                      phase_nxt    = (new_count_r >= new_length_r) ? PH_DONE : PH_CONTROL;
                    end
                  end
                endcase
              end
            end
            PH_DIFF, PH_EXTRA: begin
              new_count_nxt = count_inc;
              remaining_nxt = remaining_r - 31'd1;
              // Old position advances on diff bytes; the seek applies at the end.
              old_pos_nxt   = old_pos_r + seek_term + {63'd0, phase_r == PH_DIFF};
              if (remaining_r == 31'd1) begin
                if (!finish) begin
                  phase_nxt     = PH_EXTRA;
                  remaining_nxt = extra_len_r;
                end else begin
                  ctrl_cnt_nxt = '0;
                  phase_nxt    = (count_inc >= new_length_r) ? PH_DONE : PH_CONTROL;
                end
              end
              rd_en    = (phase_r == PH_DIFF) && in_range;
              res_load = 1'b1;
              s1_nxt   = '{data: in_byte, add: rd_en, pos: new_count_r, status: ST_DATA,
                           last: phase_nxt == PH_DONE};
            end
            default: begin
              // Patch bytes outside a run are dropped.
            end
          endcase
        end
        default: begin
        end
      endcase
    end

    if (res_load) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  bdpa_ram #(
    .WIDTH (8),
    .DEPTH (OLD_DEPTH)
  ) u_old_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr_ext[AW-1:0]),
    .wdata (in_byte),
    .re    (rd_en),
    .raddr (old_pos_r[AW-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      old_length_r <= '0;
      new_length_r <= '0;
      phase_r      <= PH_IDLE;
      ctrl_cnt_r   <= '0;
      diff_len_r   <= '0;
      extra_len_r  <= '0;
      seek_r       <= '0;
      old_pos_r    <= '0;
      new_count_r  <= '0;
      remaining_r  <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_OLD_LENGTH: old_length_r <= cfg_wdata[12:0];
          CFG_NEW_LENGTH: new_length_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      phase_r     <= phase_nxt;
      ctrl_cnt_r  <= ctrl_cnt_nxt;
      diff_len_r  <= diff_len_nxt;
      extra_len_r <= extra_len_nxt;
      seek_r      <= seek_nxt;
      old_pos_r   <= old_pos_nxt;
      new_count_r <= new_count_nxt;
      remaining_r <= remaining_nxt;
      s1_valid_r  <= s1_valid_nxt;
      if (s1_go) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    sum_r   <= sum_nxt;
    s1_r    <= s1_nxt;
    if (s1_go && s1_valid_r) begin
      out_r      <= s1_r;
      out_byte_r <= s1_r.data + (s1_r.add ? rd_data : 8'd0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r.pos, out_byte_r};
  assign out_tuser  = out_r.status;
  assign out_tlast  = out_r.last;

  // A run is never entered with nothing left to do.
  a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DIFF || phase_r == PH_EXTRA) |-> (remaining_r != '0))
    else $error("diff or extra run active with zero bytes remaining");

  // The control counter never passes one triple.
  a_ctrl_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_CONTROL) |-> (ctrl_cnt_r < 5'(CTRL_BYTES)))
    else $error("control byte count beyond one triple");

  // A store read always lands in the read stage with the add flag set.
  a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> (s1_valid_r && s1_r.add))
    else $error("store read issued without a waiting result");

  // Patch bytes after the end or an error create no result.
  a_no_result_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && cmd == CMD_PATCH && (phase_r == PH_DONE || phase_r == PH_ERROR))
      |=> !s1_valid_r)
    else $error("result created for a patch byte after the end");

endmodule
`default_nettype wire

/* bench/bdpa_bench_pkg.sv */
package bdpa_bench_pkg;
  import bdpa_pkg::*;

  localparam int IMAGE_DEPTH = 4096;
  localparam logic [63:0] POS_MASK = 64'h7FFF_FFFF;
  localparam logic [63:0] MAG_MASK = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [7:0]  new_byte;
    logic [30:0] position;
    status_t     status;
    logic        last;
  } new_item_t;

  typedef enum int {
    AWAIT_START,
    READ_CONTROL,
    ADD_DIFF,
    COPY_EXTRA,
    IMAGE_DONE,
    PATCH_FAILED
  } patch_phase_t;

  // Rebuilds the new image from the accepted items and keeps the bytes still to come.
  class image_rebuilder;
    new_item_t    pending_bytes[$];
    int           wrong_results;
    logic [7:0]   old_image [IMAGE_DEPTH];
    logic [12:0]  old_length;
    logic [30:0]  new_length;
    logic [63:0]  old_pos;
    logic [63:0]  new_count;
    logic [63:0]  ctrl_word;
    logic [63:0]  diff_len;
    logic [63:0]  extra_len;
    logic [63:0]  seek;
    logic [63:0]  remaining;
    int           ctrl_count;
    patch_phase_t phase;

    function new();
      wrong_results = 0;
      old_length = '0;
      new_length = '0;
      clear_run();
      phase = AWAIT_START;
    endfunction

    function void clear_run();
      old_pos = '0;
      new_count = '0;
      ctrl_word = '0;
      diff_len = '0;
      extra_len = '0;
      seek = '0;
      remaining = '0;
      ctrl_count = 0;
    endfunction

    function void write_register(logic index, logic [30:0] value);
      if (index == CFG_OLD_LENGTH) old_length = value[12:0];
      else new_length = value;
    endfunction

    function void push_item(logic [7:0] b, logic [30:0] p, status_t s, logic l);
      new_item_t e;
      e.new_byte = b;
      e.position = p;
      e.status = s;
      e.last = l;
      pending_bytes.push_back(e);
    endfunction

    function void raise_error();
      phase = PATCH_FAILED;
      push_item(8'd0, new_count[30:0], ST_ERROR, 1'b1);
    endfunction

    // Minus zero is a valid zero; a negative or over-wide magnitude is refused.
    function bit take_length(logic [63:0] raw, output logic [63:0] len);
      logic [63:0] mag;
      mag = raw & MAG_MASK;
      len = '0;
      if (mag == 0) return 1'b1;
      if (raw[63]) return 1'b0;
      if (mag > POS_MASK) return 1'b0;
      len = mag;
      return 1'b1;
    endfunction

    function void finish_triple();
      old_pos = old_pos + seek;
      ctrl_count = 0;
      phase = (new_count >= 64'(new_length)) ? IMAGE_DONE : READ_CONTROL;
    endfunction

    function void control_byte(logic [7:0] b);
      int k;
      logic [63:0] len;
      logic [63:0] mag;
      k = ctrl_count % 8;
      if (k == 0) ctrl_word = 64'(b);
      else ctrl_word = ctrl_word | (64'(b) << (8 * k));
      ctrl_count++;
      if (k != 7) return;
      if (ctrl_count == 8) begin
        if (!take_length(ctrl_word, len)) begin
          raise_error();
          return;
        end
        diff_len = len;
        if (new_count + diff_len > 64'(new_length)) raise_error();
      end else if (ctrl_count == 16) begin
        if (!take_length(ctrl_word, len)) begin
          raise_error();
          return;
        end
        extra_len = len;
        if (new_count + diff_len + extra_len > 64'(new_length)) raise_error();
      end else begin
        mag = ctrl_word & MAG_MASK;
        seek = ctrl_word[63] ? (64'd0 - mag) : mag;
        if (diff_len != 0) begin
          phase = ADD_DIFF;
          remaining = diff_len;
        end else if (extra_len != 0) begin
          phase = COPY_EXTRA;
          remaining = extra_len;
        end else begin
          finish_triple();
        end
      end
    endfunction

    function void accept_item(cmd_t cmd, logic [7:0] b, logic [11:0] addr);
      logic [7:0]  v;
      logic [30:0] pos;
      logic [63:0] limit;
      case (cmd)
        CMD_LOAD: old_image[addr] = b;
        CMD_START: begin
          clear_run();
          if (new_length == 0) begin
            phase = IMAGE_DONE;
            push_item(8'd0, 31'd0, ST_DONE, 1'b1);
          end else begin
            phase = READ_CONTROL;
          end
        end
        CMD_PATCH: begin
          if (phase == READ_CONTROL) begin
            control_byte(b);
          end else if (phase == ADD_DIFF || phase == COPY_EXTRA) begin
            v = b;
            pos = new_count[30:0];
            if (phase == ADD_DIFF) begin
              limit = (old_length > 13'd4096) ? 64'(IMAGE_DEPTH) : 64'(old_length);
              if (old_pos < limit) v = v + old_image[old_pos[11:0]];
              old_pos = old_pos + 64'd1;
            end
            new_count = (new_count + 64'd1) & POS_MASK;
            remaining = remaining - 64'd1;
            if (remaining == 0) begin
              if (phase == ADD_DIFF && extra_len != 0) begin
                phase = COPY_EXTRA;
                remaining = extra_len;
              end else begin
                finish_triple();
              end
            end
            push_item(v, pos, ST_DATA, phase == IMAGE_DONE);
          end
        end
        default: ;
      endcase
    endfunction

    function void note_wrong(string msg);
      wrong_results++;
      if (wrong_results <= 10) $display("mismatch: %s", msg);
    endfunction

    function void compare_result(logic [7:0] b, logic [30:0] p, logic [1:0] s, logic l);
      new_item_t e;
      if (pending_bytes.size() == 0) begin
        note_wrong($sformatf("unexpected item: byte %02h position %0d status %0d last %0b",
                             b, p, s, l));
        return;
      end
      e = pending_bytes.pop_front();
      if (b !== e.new_byte || p !== e.position || s !== e.status || l !== e.last)
        note_wrong($sformatf({"expected byte %02h position %0d status %0d last %0b, ",
                              "got byte %02h position %0d status %0d last %0b"},
                             e.new_byte, e.position, e.status, e.last, b, p, s, l));
    endfunction
  endclass

endpackage

/* bench/binary_delta_patch_apply_test.sv */
module binary_delta_patch_apply_test;
  import bdpa_pkg::*;
  import bdpa_bench_pkg::*;

  // Old image entries loaded at the start, from address zero up; the top entry is
  // loaded as well.
  localparam int LOADED_BYTES = 256;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [7:0] data_byte, [19:8] old_address, rest zero
  logic [1:0]  in_tuser;   // [1:0] command
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [7:0] new_byte, [38:8] new_position, rest zero
  logic [1:0]  out_tuser;  // [1:0] status
  logic        out_tlast;
  logic        cfg_we;
  logic        cfg_index;
  logic [30:0] cfg_wdata;

  binary_delta_patch_apply i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // The rebuilder predicts every new byte from the items the block has taken.
  image_rebuilder rebuilder;

  // Cycles for which the receiver must refuse items; counted down by the receiver itself.
  int receiver_hold = 0;
  // Set for the closing part of the run, where neither side idles.
  bit calm = 1'b0;
  // Items taken by the block so far, image loads included.
  int items_sent = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net: a correct run finishes far inside this bound.
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver side. Readiness changes only at the falling edge; now and then it drops for a
  // burst of idling, and a long hold can be requested by the stimulus.
  initial begin
    int gap;
    gap = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (receiver_hold > 0) begin
        receiver_hold--;
        out_tready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(0, 12);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Every result item taken at a rising edge is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      rebuilder.compare_result(out_tdata[7:0], out_tdata[38:8], out_tuser, out_tlast);
  end

  // Offers one item from the next falling edge, possibly after a burst of idling, and
  // returns once the block has taken it. The next driver call starts at the following
  // falling edge, so tvalid stays high across back-to-back items.
  task automatic offer(cmd_t cmd, logic [7:0] data, logic [11:0] addr);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 13);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {4'd0, addr, data};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rebuilder.accept_item(cmd, data, addr);
    items_sent++;
  endtask

  // The address field is ignored for patch bytes, so it carries noise.
  task automatic patch_byte(logic [7:0] b);
    offer(CMD_PATCH, b, 12'($urandom));
  endtask

  // A control value goes out least significant byte first.
  task automatic send_word(logic [63:0] w);
    for (int i = 0; i < 8; i++) patch_byte(w[8 * i +: 8]);
  endtask

  // Withdraws the input, waits for every predicted item and lets the pipeline empty.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (rebuilder.pending_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Registers are only written once the block has gone quiet.
  task automatic write_register(logic index, logic [30:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    rebuilder.write_register(index, value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly short seeks either way; now and then a huge one that wraps the old
  // position, or a minus zero.
  function automatic logic [63:0] random_seek();
    case ($urandom_range(0, 9))
      0: return {$urandom, $urandom};
      1: return {1'b1, 63'd0};
      default: return {1'($urandom_range(0, 1)), 63'($urandom_range(0, 40))};
    endcase
  endfunction

  // One well-formed control triple followed by its diff and extra bytes. Now and then
  // an old image byte near the read position is rewritten, or a stray item slips in,
  // in the middle of the diff run.
  task automatic send_triple(int d, int e, logic [63:0] seek_word);
    send_word(64'(d));
    send_word(64'(e));
    send_word(seek_word);
    for (int i = 0; i < d; i++) begin
      if ($urandom_range(0, 15) == 0)
        offer(CMD_LOAD, 8'($urandom), rebuilder.old_pos[11:0] + 12'($urandom_range(0, 1)));
      if ($urandom_range(0, 31) == 0) offer(CMD_NONE, 8'($urandom), 12'($urandom));
      patch_byte(8'($urandom));
    end
    repeat (e) patch_byte(8'($urandom));
  endtask

  // A whole patch run: new settings, a start, then triples until the image is complete
  // or a broken control value sends the block into error. With squeeze set the run is
  // long and clean, and the receiver holds off for a while just after the start.
  task automatic patch_session(bit squeeze);
    int total;
    int left;
    int d;
    int e;
    int pick;
    logic [63:0] seek_word;
    logic [63:0] seek_val;
    logic [63:0] target;
    settle();
    case ($urandom_range(0, 5))
      0: write_register(CFG_OLD_LENGTH, 31'd0);
      1: write_register(CFG_OLD_LENGTH, 31'd1);
      2: write_register(CFG_OLD_LENGTH, 31'd4096);
      3: write_register(CFG_OLD_LENGTH, 31'($urandom_range(4097, 8191)));
      default: write_register(CFG_OLD_LENGTH, 31'($urandom_range(1, 4096)));
    endcase
    if (squeeze) total = 120;
    else if ($urandom_range(0, 11) == 0) total = 0;
    else total = $urandom_range(1, 80);
    write_register(CFG_NEW_LENGTH, 31'(total));
    offer(CMD_START, 8'($urandom), 12'($urandom));
    if (squeeze) receiver_hold = 80;
    left = total;
    while (left > 0) begin
      d = $urandom_range(0, (left < 20) ? left : 20);
      e = $urandom_range(0, ((left - d) < 12) ? (left - d) : 12);
      pick = squeeze ? 99 : $urandom_range(0, 29);
      // Occasionally the sender waits for every outstanding byte before going on.
      if (pick == 5) settle();
      if (pick == 0) begin
        // Negative diff length.
        send_word({1'b1, 63'($urandom_range(1, 300))});
        left = 0;
      end else if (pick == 1) begin
        // Diff length running past the new image.
        send_word(64'(left + $urandom_range(1, 5)));
        left = 0;
      end else if (pick == 2) begin
        // Extra length above the largest positive 32-bit value.
        send_word(64'(d));
        send_word({1'b0, 31'($urandom), 1'b1, 31'($urandom)});
        left = 0;
      end else if (pick == 3) begin
        // Diff and extra together one byte too long.
        send_word(64'(d));
        send_word(64'(left - d + 1));
        left = 0;
      end else if (pick == 4) begin
        // Restart part way through a control triple.
        repeat ($urandom_range(0, 23)) patch_byte(8'($urandom));
        offer(CMD_START, 8'($urandom), 12'($urandom));
        left = total;
      end else begin
        seek_word = random_seek();
        seek_val = seek_word[63] ? (64'd0 - (seek_word & MAG_MASK)) : (seek_word & MAG_MASK);
        target = rebuilder.old_pos + 64'(d) + seek_val;
        // A seek that would let the next diff run read past the loaded entries goes
        // back to the start of the old image instead.
        if (target >= 64'(LOADED_BYTES - 20) && target < 64'(IMAGE_DEPTH)) begin
          seek_val = 64'd0 - rebuilder.old_pos - 64'(d);
          seek_word = seek_val[63] ? {1'b1, 63'(64'd0 - seek_val)} : seek_val;
        end
        send_triple(d, e, seek_word);
        left -= d + e;
      end
    end
    // Patch bytes after done or error must be dropped silently.
    if ($urandom_range(0, 3) == 0) repeat (3) patch_byte(8'($urandom));
  endtask

  initial begin
    bit squeezed;
    rebuilder = new();
    squeezed = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_NONE;
    cfg_we = 1'b0;
    cfg_index = CFG_OLD_LENGTH;
    cfg_wdata = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Fill the low part of the old image and its top entry; the stimulus keeps every
    // store read inside them.
    for (int a = 0; a < LOADED_BYTES; a++) offer(CMD_LOAD, 8'($urandom), 12'(a));
    offer(CMD_LOAD, 8'($urandom), 12'(IMAGE_DEPTH - 1));

    // Directed part. Straight out of reset nothing is running and the new length is
    // zero, so a start reports an empty image at once.
    patch_byte(8'hFF);
    offer(CMD_NONE, 8'hA5, 12'hFFF);
    offer(CMD_START, 8'h00, 12'h000);
    patch_byte(8'h00);

    // Old length beyond the store is clipped to its depth; the largest diff length is
    // accepted against the largest new length. A start in the middle of the diff run
    // begins again, then minus zero is taken as a zero diff and an extra length just
    // above the 31-bit limit is refused.
    settle();
    write_register(CFG_OLD_LENGTH, 31'd8191);
    write_register(CFG_NEW_LENGTH, 31'h7FFF_FFFF);
    offer(CMD_START, 8'h00, 12'h000);
    send_word(64'h0000_0000_7FFF_FFFF);
    send_word(64'd0);
    send_word({1'b1, 63'd1});
    patch_byte(8'h00);
    patch_byte(8'hFF);
    patch_byte(8'h80);
    offer(CMD_START, 8'hFF, 12'hFFF);
    send_word({1'b1, 63'd0});
    send_word(64'h0000_0000_8000_0000);
    patch_byte(8'h12);

    // The last byte of a full-depth image is read, the one after it passes through.
    // Then the new length is cut to the count already reached, so an empty triple
    // finishes the image without producing an item.
    settle();
    write_register(CFG_OLD_LENGTH, 31'd4096);
    write_register(CFG_NEW_LENGTH, 31'd5);
    offer(CMD_START, 8'h00, 12'h000);
    send_triple(0, 0, {1'b0, 63'd4095});
    send_triple(2, 0, 64'd0);
    settle();
    write_register(CFG_NEW_LENGTH, 31'd2);
    send_triple(0, 0, 64'd0);
    patch_byte(8'h55);

    // Broken lengths: negative diff, extra overrunning the image, diff overrunning it.
    settle();
    write_register(CFG_NEW_LENGTH, 31'd100);
    offer(CMD_START, 8'h00, 12'h000);
    send_word({1'b1, 63'd5});
    offer(CMD_START, 8'h00, 12'h000);
    send_word(64'd60);
    send_word(64'd41);
    offer(CMD_START, 8'h00, 12'h000);
    send_word(64'd101);

    // Random part. One run part way through is a long clean one while the receiver
    // holds off, so the block fills up and stops taking items.
    while (items_sent < 800) begin
      if (items_sent > 680) calm = 1'b1;
      if (!squeezed && items_sent > 300) begin
        squeezed = 1'b1;
        patch_session(1'b1);
      end else begin
        patch_session(1'b0);
      end
    end

    settle();
    if (rebuilder.wrong_results == 0 && rebuilder.pending_bytes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
